[rtl/line_follow_pid_pivot_controller_top_defines.svh]
// assertion macros for the line follower block
// the assertions compile only when SYNTH is not defined
`ifndef LINE_FOLLOW_PID_PIVOT_CONTROLLER_TOP_DEFINES_SVH
`define LINE_FOLLOW_PID_PIVOT_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTH
`define LFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfp check failed");
`define LFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfp check failed");
`else
`define LFP_ASSERT_NOW(lbl, ante, cons)
`define LFP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/lfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

	// mode codes
	localparam logic [1:0] MODE_TRACK = 2'd0;
	localparam logic [1:0] MODE_PIVOT = 2'd1;
	localparam logic [1:0] MODE_EXIT  = 2'd2;

	// direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_PIN1 = 2'd1;
	localparam logic [1:0] DIR_PIN2 = 2'd2;

	// register indexes
	localparam logic [2:0] REG_GAIN_P      = 3'd0;
	localparam logic [2:0] REG_GAIN_I      = 3'd1;
	localparam logic [2:0] REG_GAIN_D      = 3'd2;
	localparam logic [2:0] REG_CENTER_POS  = 3'd3;
	localparam logic [2:0] REG_SPIN_SPEED  = 3'd4;
	localparam logic [2:0] REG_EXIT_FRAMES = 3'd5;

	localparam logic [7:0] CENTER_RESET = 8'd80;
	localparam logic [6:0] SPIN_RESET   = 7'd10;
	localparam logic [3:0] EXIT_RESET   = 4'd3;

	localparam logic [6:0] DRIVE_LIMIT = 7'd100;
	localparam logic [9:0] PWM_TOP     = 10'd1000;

	localparam int Q8_W = 42;

	typedef struct packed {
		logic              track;
		logic [1:0]        mode;
		logic signed [7:0] left_d;
		logic signed [7:0] right_d;
		logic signed [8:0] err;
		logic signed [23:0] sum;
		logic signed [9:0] derr;
		logic signed [7:0] base;
	} lfp_item_t;

	typedef struct packed {
		logic [9:0] cmp;
		logic [1:0] dir;
	} lfp_drive_t;

	// q34.8 to drive: truncate toward zero, then clamp to the drive limit
	function automatic logic signed [7:0] lfp_limit(input logic signed [Q8_W-1:0] v);
		logic signed [Q8_W-9:0] q;
		logic signed [7:0] res;
		q = v[Q8_W-1:8];
		if (v[Q8_W-1] && (v[7:0] != 8'd0)) begin
			q = q + (Q8_W-8)'(1);
		end
		if (q > $signed({{(Q8_W-15){1'b0}}, DRIVE_LIMIT})) begin
			res = $signed({1'b0, DRIVE_LIMIT});
		end else if (q < -$signed({{(Q8_W-15){1'b0}}, DRIVE_LIMIT})) begin
			res = -$signed({1'b0, DRIVE_LIMIT});
		end else begin
			res = q[7:0];
		end
		return res;
	endfunction

	function automatic lfp_drive_t lfp_drive(input logic signed [7:0] d);
		logic [7:0] mag;
		lfp_drive_t r;
		mag = d[7] ? 8'(-d) : 8'(d);
		r.cmp = PWM_TOP - {mag[6:0], 3'b000} - {1'b0, mag, 1'b0};
		if (d[7]) begin
			r.dir = DIR_PIN1;
		end else if (d != 8'sd0) begin
			r.dir = DIR_PIN2;
		end else begin
			r.dir = DIR_STOP;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/lfp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [23:0]          in_data,
	input  wire logic [7:0]           center_pos,
	input  wire logic [6:0]           spin_speed,
	input  wire logic [3:0]           exit_frames,
	input  wire logic                 q_full,
	output logic                      push,
	output lfp_pkg::lfp_item_t        push_item
);

	logic [7:0]        pos;
	logic signed [7:0] base;
	logic [3:0]        seen;

	logic               pivoting_q, pause_q, spin_left_q;
	logic [3:0]         stop_count_q;
	logic signed [23:0] sum_q;
	logic signed [8:0]  prev_q;

	logic               pivoting_d, pause_d, spin_left_d;
	logic [3:0]         stop_count_d;
	logic signed [23:0] sum_d;
	logic signed [8:0]  prev_d;

	logic signed [8:0]  err_w;
	logic signed [24:0] sum_w;
	logic signed [23:0] sum_sat;
	logic signed [9:0]  derr_w;
	logic signed [7:0]  spin_s;
	logic [3:0]         count_dec;

	assign pos  = in_data[7:0];
	assign base = $signed(in_data[15:8]);
	assign seen = in_data[19:16];

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign err_w  = $signed({1'b0, pos} - {1'b0, center_pos});
	assign sum_w  = $signed({sum_q[23], sum_q}) + $signed({{16{err_w[8]}}, err_w});
	assign sum_sat = (sum_w[24] != sum_w[23]) ?
		(sum_w[24] ? 24'sh800000 : 24'sh7fffff) : sum_w[23:0];
	assign derr_w = $signed({err_w[8], err_w}) - $signed({prev_q[8], prev_q});
	assign spin_s = (spin_speed > lfp_pkg::DRIVE_LIMIT) ?
		$signed({1'b0, lfp_pkg::DRIVE_LIMIT}) : $signed({1'b0, spin_speed});
	assign count_dec = stop_count_q - 4'd1;

	always_comb begin
		pivoting_d   = pivoting_q;
		pause_d      = pause_q;
		spin_left_d  = spin_left_q;
		stop_count_d = stop_count_q;
		sum_d        = sum_q;
		prev_d       = prev_q;

		push_item.track   = 1'b0;
		push_item.mode    = lfp_pkg::MODE_EXIT;
		push_item.left_d  = 8'sd0;
		push_item.right_d = 8'sd0;
		push_item.err     = err_w;
		push_item.sum     = sum_sat;
		push_item.derr    = derr_w;
		push_item.base    = base;

		priority if (stop_count_q != 4'd0) begin
			stop_count_d = count_dec;
			if (count_dec == 4'd0) begin
				pivoting_d  = 1'b0;
				spin_left_d = 1'b0;
				sum_d       = '0;
				prev_d      = '0;
			end
		end else if (pivoting_q && (seen >= 4'd2)) begin
			stop_count_d = (exit_frames == 4'd0) ? 4'd1 : exit_frames;
		end else if (pivoting_q) begin
			push_item.mode = lfp_pkg::MODE_PIVOT;
			if (pause_q) begin
				pause_d = 1'b0;
			end else if (spin_left_q) begin
				push_item.left_d  = -spin_s;
				push_item.right_d = spin_s;
			end else begin
				push_item.left_d  = spin_s;
				push_item.right_d = -spin_s;
			end
		end else if (seen == 4'd0) begin
			// line lost: pause one frame, then spin toward the last side seen
			push_item.mode = lfp_pkg::MODE_PIVOT;
			pivoting_d     = 1'b1;
			pause_d        = 1'b1;
			spin_left_d    = (pos < center_pos);
		end else begin
			push_item.track = 1'b1;
			push_item.mode  = lfp_pkg::MODE_TRACK;
			sum_d           = sum_sat;
			prev_d          = err_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivoting_q   <= 1'b0;
			pause_q      <= 1'b0;
			spin_left_q  <= 1'b0;
			stop_count_q <= '0;
			sum_q        <= '0;
			prev_q       <= '0;
		end else if (push) begin
			pivoting_q   <= pivoting_d;
			pause_q      <= pause_d;
			spin_left_q  <= spin_left_d;
			stop_count_q <= stop_count_d;
			sum_q        <= sum_d;
			prev_q       <= prev_d;
		end
	end

endmodule

`default_nettype wire

[rtl/lfp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "line_follow_pid_pivot_controller_top_defines.svh"

module lfp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire lfp_pkg::lfp_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    pop_valid,
	output lfp_pkg::lfp_item_t      pop_item
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	lfp_pkg::lfp_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`LFP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH))
	`LFP_ASSERT_NOW(a_no_overrun, push, !full)
	`LFP_ASSERT_NEXT(a_push_holds, push && !pop, cnt_q != '0)

endmodule

`default_nettype wire

[rtl/lfp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [15:0] gain_p,
	input  wire logic signed [15:0] gain_i,
	input  wire logic signed [15:0] gain_d,
	input  wire logic               q_valid,
	input  wire lfp_pkg::lfp_item_t q_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [23:0]             out_data,
	output logic [1:0]              out_mode
);

	localparam int QW = lfp_pkg::Q8_W;

	// stage 1: products
	logic               valid_s1, track_s1;
	logic [1:0]         mode_s1;
	logic signed [7:0]  left_s1, right_s1, base_s1;
	logic signed [24:0] prod_p_s1;
	logic signed [39:0] prod_i_s1;
	logic signed [25:0] prod_d_s1;

	// stage 2: q34.8 wheel sums
	logic                  valid_s2, track_s2;
	logic [1:0]            mode_s2;
	logic signed [7:0]     left_s2, right_s2;
	logic signed [QW-1:0]  lq_s2, rq_s2;

	logic out_valid_q;
	logic [23:0] out_data_q;
	logic [1:0]  out_mode_q;

	logic en_out, en_s2, en_s1;
	logic signed [QW-1:0] pid_w, base_q_w;
	logic signed [7:0] left_fin, right_fin;
	lfp_pkg::lfp_drive_t drv_l, drv_r;

	assign en_out = !out_valid_q || out_ready;
	assign en_s2  = !valid_s2 || en_out;
	assign en_s1  = !valid_s1 || en_s2;
	assign pop    = q_valid && en_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			track_s1  <= q_item.track;
			mode_s1   <= q_item.mode;
			left_s1   <= q_item.left_d;
			right_s1  <= q_item.right_d;
			base_s1   <= q_item.base;
			prod_p_s1 <= $signed({{9{gain_p[15]}}, gain_p})
				* $signed({{16{q_item.err[8]}}, q_item.err});
			prod_i_s1 <= $signed({{24{gain_i[15]}}, gain_i})
				* $signed({{16{q_item.sum[23]}}, q_item.sum});
			prod_d_s1 <= $signed({{10{gain_d[15]}}, gain_d})
				* $signed({{16{q_item.derr[9]}}, q_item.derr});
		end
	end

	assign pid_w = $signed({{(QW-25){prod_p_s1[24]}}, prod_p_s1})
		+ $signed({{(QW-40){prod_i_s1[39]}}, prod_i_s1})
		+ $signed({{(QW-26){prod_d_s1[25]}}, prod_d_s1});
	assign base_q_w = $signed({{(QW-16){base_s1[7]}}, base_s1, 8'd0});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			track_s2 <= track_s1;
			mode_s2  <= mode_s1;
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			lq_s2    <= base_q_w + pid_w;
			rq_s2    <= base_q_w - pid_w;
		end
	end

	assign left_fin  = track_s2 ? lfp_pkg::lfp_limit(lq_s2) : left_s2;
	assign right_fin = track_s2 ? lfp_pkg::lfp_limit(rq_s2) : right_s2;
	assign drv_l     = lfp_pkg::lfp_drive(left_fin);
	assign drv_r     = lfp_pkg::lfp_drive(right_fin);

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			out_data_q <= {drv_r.dir, drv_r.cmp, drv_l.dir, drv_l.cmp};
			out_mode_q <= mode_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= q_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_mode  = out_mode_q;

endmodule

`default_nettype wire

[rtl/line_follow_pid_pivot_controller_top.sv]
// a result passes through the queue, the stage 1 products, the stage 2 wheel sums and the output register
// throughput: one frame per cycle while the queue is not full; the front updates its state on each accepted frame
// a queue of QUEUE_DEPTH frames lets the front keep taking frames while the back stalls
// reset: arst_n clears the pivot, countdown and pid state, empties the queue and pipeline
// and returns the registers to gain 0, centre 80, spin 10, exit 3
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_pivot_controller_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// frame input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] line_pos, [15:8] base_speed, [19:16] lines_seen, [23:20] zero
	input  wire logic [23:0] s_tdata,
	// drive output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [9:0] left_compare, [11:10] left_dir, [21:12] right_compare, [23:22] right_dir
	output logic [23:0]      m_tdata,
	// [1:0] mode
	output logic [1:0]       m_tuser,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// configuration registers: the user must write them only while the block is idle; the block does not enforce this
	logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;
	logic [7:0]         center_pos_q;
	logic [6:0]         spin_speed_q;
	logic [3:0]         exit_frames_q;

	logic [2:0] reg_idx;
	logic       reg_wr;

	// front to queue and queue to back
	logic               push, q_full, pop, q_valid;
	lfp_pkg::lfp_item_t push_item, q_item;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			center_pos_q  <= lfp_pkg::CENTER_RESET;
			spin_speed_q  <= lfp_pkg::SPIN_RESET;
			exit_frames_q <= lfp_pkg::EXIT_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				lfp_pkg::REG_GAIN_P:      gain_p_q      <= $signed(pwdata[15:0]);
				lfp_pkg::REG_GAIN_I:      gain_i_q      <= $signed(pwdata[15:0]);
				lfp_pkg::REG_GAIN_D:      gain_d_q      <= $signed(pwdata[15:0]);
				lfp_pkg::REG_CENTER_POS:  center_pos_q  <= pwdata[7:0];
				lfp_pkg::REG_SPIN_SPEED:  spin_speed_q  <= pwdata[6:0];
				lfp_pkg::REG_EXIT_FRAMES: exit_frames_q <= pwdata[3:0];
				default: begin
					// addresses past the register list are ignored
				end
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		unique case (reg_idx)
			lfp_pkg::REG_GAIN_P:      prdata = {16'd0, gain_p_q};
			lfp_pkg::REG_GAIN_I:      prdata = {16'd0, gain_i_q};
			lfp_pkg::REG_GAIN_D:      prdata = {16'd0, gain_d_q};
			lfp_pkg::REG_CENTER_POS:  prdata = {24'd0, center_pos_q};
			lfp_pkg::REG_SPIN_SPEED:  prdata = {25'd0, spin_speed_q};
			lfp_pkg::REG_EXIT_FRAMES: prdata = {28'd0, exit_frames_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// front: owns the pivot / countdown / pid state and classifies each frame
	lfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_data     (s_tdata),
		.center_pos  (center_pos_q),
		.spin_speed  (spin_speed_q),
		.exit_frames (exit_frames_q),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// short queue so the front and the back stall independently
	lfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// back: gain products, wheel sums, limiting and pwm encoding
	lfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain_p    (gain_p_q),
		.gain_i    (gain_i_q),
		.gain_d    (gain_d_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_mode  (m_tuser)
	);

endmodule

`default_nettype wire
